### rtl/core/gbts_pkg.sv
// ---------------------------------------------------------------------------
// gbts_pkg: shared codes for the gap buffer text store
// Request kinds, result status codes and stream field widths.
// ---------------------------------------------------------------------------
`default_nettype none

package gbts_pkg;

  // Request kinds (codes 6 and 7 are unused and get status ignored)
  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_DELETE = 3'd1;
  localparam logic [2:0] REQ_LEFT   = 3'd2;
  localparam logic [2:0] REQ_RIGHT  = 3'd3;
  localparam logic [2:0] REQ_SEEK   = 3'd4;
  localparam logic [2:0] REQ_READ   = 3'd5;

  // Result status
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Field widths
  localparam int KIND_W = 3;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 11;
  localparam int STAT_W = 2;

  localparam int S_DATA_W = 24;  // char_in + position, padded to bytes
  localparam int M_DATA_W = 32;  // data_out + cursor + content_length + status

endpackage

`default_nettype wire

### rtl/core/gap_buffer_text_store_top.sv
// ---------------------------------------------------------------------------
// gap_buffer_text_store_top: gap buffer of text bytes in one block RAM
// Usage: each request on the slave stream is one edit or query on the text:
// insert at the cursor, delete before the cursor, move the cursor left or
// right, seek the cursor to a content position, or read a content byte.
// Every request gives exactly one result on the master stream with the
// returned byte, the new cursor, the content length and a status code.
// Sequence: insert, delete, left, right, read and unused codes do one RAM
// read, then modify/write and load the result register. A seek that is
// ignored or lands on the cursor takes the same steps. A seek over d > 0
// bytes takes the start step, then one RAM read and one RAM write for each
// byte moved across the gap, then a final step that loads the result
// register. One request is in work at a time; the next one is taken once
// the current result is registered, even while that result still waits
// for the receiver.
// Reset: cursor goes to 0 and the whole store becomes gap; the RAM itself is
// not cleared, since only written bytes are ever read back.
// Stall: when the receiver holds m_tready low, the finished result is held in the
// output register; a following request completes its RAM read (a moving seek its walk
// over the gap), then waits, with no state change, until the output register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module gap_buffer_text_store_top
  import gbts_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // request stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // [7:0] char_in, [18:8] position, rest zero
  input  wire logic [KIND_W-1:0]   s_tuser,   // [2:0] req_type
  // result stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata    // [7:0] data_out, [18:8] cursor,
                                              // [29:19] content_length, [31:30] status
);

  // address width of the store, and width that can hold DEPTH itself
  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);
  // working width for sums of positions and gap sizes
  localparam int XW = ((PW > POS_W) ? PW : POS_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEEK_RD,
    S_SEEK_WR
  } state_t;

  state_t state, state_next;

  // gap bounds: text before the cursor in [0, gs), text after in [gl, DEPTH)
  logic [PW-1:0] gs, gs_next;
  logic [PW-1:0] gl, gl_next;

  // latched request
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] char_q;
  logic [POS_W-1:0]  pos_q;

  // text RAM
  logic [CHAR_W-1:0] mem [DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;

  // result
  logic              push;
  logic [CHAR_W-1:0] res_data;
  logic [STAT_W-1:0] res_status;

  // incoming request fields
  logic [KIND_W-1:0] in_kind;
  logic [POS_W-1:0]  in_pos;
  logic [CHAR_W-1:0] in_char;

  logic [XW-1:0] gs_x, gl_x, gap_x, len_x, in_pos_x, pos_x;
  logic [XW-1:0] gs_nx, len_nx;
  logic [XW-1:0] issue_addr;
  logic          out_free;
  logic          seek_left;

  assign in_kind = s_tuser;
  assign in_char = s_tdata[CHAR_W-1:0];
  assign in_pos  = s_tdata[CHAR_W+POS_W-1:CHAR_W];

  assign gs_x     = XW'(gs);
  assign gl_x     = XW'(gl);
  assign gap_x    = gl_x - gs_x;
  assign len_x    = XW'(DEPTH) - gap_x;
  assign in_pos_x = XW'(in_pos);
  assign pos_x    = XW'(pos_q);

  assign gs_nx  = XW'(gs_next);
  assign len_nx = XW'(DEPTH) - (XW'(gl_next) - XW'(gs_next));

  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign seek_left = (pos_x < gs_x);

  // read address for the request being accepted
  always_comb begin
    case (in_kind)
      REQ_DELETE, REQ_LEFT: issue_addr = gs_x - XW'(1);
      REQ_RIGHT:            issue_addr = gl_x;
      REQ_READ:             issue_addr = (in_pos_x < gs_x) ? in_pos_x : in_pos_x + gap_x;
      default:              issue_addr = gs_x;
    endcase
  end

  always_comb begin
    state_next = state;
    gs_next    = gs;
    gl_next    = gl;
    mem_we     = 1'b0;
    mem_waddr  = gs[AW-1:0];
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = issue_addr[AW-1:0];
    push       = 1'b0;
    res_data   = '0;
    res_status = ST_DONE;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          mem_re     = 1'b1;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (kind == REQ_SEEK && pos_x <= len_x && pos_x != gs_x) begin
          // start walking bytes across the gap
          state_next = S_SEEK_RD;
        end else if (out_free) begin
          push       = 1'b1;
          state_next = S_IDLE;
          case (kind)
            REQ_INSERT: begin
              if (gs == gl) begin
                res_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = char_q;
                gs_next   = gs + PW'(1);
              end
            end
            REQ_DELETE: begin
              if (gs == '0) begin
                res_status = ST_IGNORED;
              end else begin
                gs_next  = gs - PW'(1);
                res_data = mem_rdata;
              end
            end
            REQ_LEFT: begin
              if (gs == '0) begin
                res_status = ST_IGNORED;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(gl_x - XW'(1));
                gs_next   = gs - PW'(1);
                gl_next   = gl - PW'(1);
              end
            end
            REQ_RIGHT: begin
              if (gl == PW'(DEPTH)) begin
                res_status = ST_IGNORED;
              end else begin
                mem_we  = 1'b1;
                gs_next = gs + PW'(1);
                gl_next = gl + PW'(1);
              end
            end
            REQ_SEEK: begin
              // past the end is ignored; seek to the cursor itself is done
              if (pos_x > len_x) begin
                res_status = ST_IGNORED;
              end
            end
            REQ_READ: begin
              if (pos_x >= len_x) begin
                res_status = ST_IGNORED;
              end else begin
                res_data = mem_rdata;
              end
            end
            default: begin
              res_status = ST_IGNORED;
            end
          endcase
        end
      end

      S_SEEK_RD: begin
        if (pos_x == gs_x) begin
          if (out_free) begin
            push       = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          // fetch the byte that crosses the gap next
          mem_re     = 1'b1;
          mem_raddr  = seek_left ? AW'(gs_x - XW'(1)) : gl[AW-1:0];
          state_next = S_SEEK_WR;
        end
      end

      S_SEEK_WR: begin
        mem_we     = 1'b1;
        state_next = S_SEEK_RD;
        if (seek_left) begin
          mem_waddr = AW'(gl_x - XW'(1));
          gs_next   = gs - PW'(1);
          gl_next   = gl - PW'(1);
        end else begin
          gs_next = gs + PW'(1);
          gl_next = gl + PW'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // text RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      gs       <= '0;
      gl       <= PW'(DEPTH);
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      gs    <= gs_next;
      gl    <= gl_next;
      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request and result payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      kind   <= in_kind;
      char_q <= in_char;
      pos_q  <= in_pos;
    end
    if (push) begin
      m_tdata <= {res_status, len_nx[POS_W-1:0], gs_nx[POS_W-1:0], res_data};
    end
  end

  // the gap never has negative size and never runs past the store
  a_gap_order: assert property (@(posedge clk) disable iff (rst)
    gs <= gl)
    else $error("gap start passed gap limit");

  a_gap_bound: assert property (@(posedge clk) disable iff (rst)
    gl <= PW'(DEPTH))
    else $error("gap limit beyond store");

  // a result only appears after the finishing step of a request
  a_push_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_EXEC || $past(state) == S_SEEK_RD))
    else $error("result loaded outside a finishing step");

  // an accepted request always leaves idle for its RAM read
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC))
    else $error("accepted request did not start");

  // the cursor moves by at most one place per cycle
  a_cursor_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (gs == $past(gs) || gs == $past(gs) + PW'(1)
                     || gs == $past(gs) - PW'(1)))
    else $error("cursor jumped");

endmodule

`default_nettype wire
